// ===== hdl/gvba_pkg.sv =====
// ----------------------------------------------------------------------------
// gvba_pkg
// Shared types, constants and helper functions of the 3D block averager.
// ----------------------------------------------------------------------------
package gvba_pkg;

    localparam int MAX_DIM      = 64;
    localparam int MAX_BLOCK    = 8;
    localparam int SAMPLE_WIDTH = 32;

    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = POS_W + 1;
    localparam int BLK_W   = $clog2(MAX_BLOCK) + 1;
    localparam int MOD_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int IDX_W   = 2 * POS_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int VOL_W   = 3 * $clog2(MAX_BLOCK) + 1;
    localparam int SUM_W   = SAMPLE_WIDTH + VOL_W - 1;
    localparam int CNT_W   = $clog2(SUM_W + 1);
    localparam int CFG_W   = 2;
    localparam int QDEPTH  = 2;

    localparam logic [CFG_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0] REG_BLOCK  = 2'd3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]        t_sum;
    typedef logic [VOL_W-1:0]               t_vol;

    typedef struct packed {
        t_sample              vx;
        t_sample              vy;
        t_sample              vz;
        logic [IDX_W-1:0]     idx;
        logic                 first;
        logic                 last;
        logic                 fin;
    } t_item;

    typedef struct packed {
        logic start;
        t_sum sx;
        t_sum sy;
        t_sum sz;
    } t_div_req;

    typedef struct packed {
        logic    busy;
        t_sample qx;
        t_sample qy;
        t_sample qz;
    } t_div_rsp;

    typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_OUT} t_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v);
        if (v == '0) return BLK_W'(1);
        if (v > BLK_W'(MAX_BLOCK)) return BLK_W'(MAX_BLOCK);
        return v;
    endfunction

    // Cube of the block edge; the edge is small, so this is a short table.
    function automatic t_vol vol_of(input logic [BLK_W-1:0] b);
        t_vol v;
        v = '0;
        for (int k = 1; k <= MAX_BLOCK; k++) begin
            if (b == BLK_W'(k)) v = VOL_W'(k * k * k);
        end
        return v;
    endfunction

endpackage

// ===== hdl/gvba_if.sv =====
// ----------------------------------------------------------------------------
// gvba_if
// Valid/ready channels carrying sample words and average words.
// ----------------------------------------------------------------------------
interface gvba_in_if;
    import gvba_pkg::*;
    logic    valid;
    logic    ready;
    t_sample in_vx;
    t_sample in_vy;
    t_sample in_vz;
    modport source (output valid, in_vx, in_vy, in_vz, input ready);
    modport sink   (input valid, in_vx, in_vy, in_vz, output ready);
endinterface

interface gvba_out_if;
    import gvba_pkg::*;
    logic    valid;
    logic    ready;
    t_sample avg_x;
    t_sample avg_y;
    t_sample avg_z;
    logic    final_cell;
    modport source (output valid, avg_x, avg_y, avg_z, final_cell, input ready);
    modport sink   (input valid, avg_x, avg_y, avg_z, final_cell, output ready);
endinterface

// ===== hdl/grid3d_vector_block_average.sv =====
// ----------------------------------------------------------------------------
// grid3d_vector_block_average
// Averages 3D vector samples over block_size cubes of a raster-ordered grid.
// ----------------------------------------------------------------------------
// Samples enter on i_in in raster order (x slowest, z fastest), one word per
// valid/ready handshake. Each finished cube leaves one word on o_out with the
// three averages and a flag on the last cell of the grid. Registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. Any write
// restarts the grid at the origin. The front tracks the position and queues
// in-range samples in a two-word queue; samples of partial edge cubes are
// dropped there. The back reads a cell's store entry in ST_IDLE and writes
// the new sum back in ST_ACC. A sample that completes a cell starts the
// divider; its quotients enter the output register once that is free.
// After reset the sizes are 64 and the block edge is 2; no clearing pass is
// needed because the first sample of a cell overwrites its store entry.
// A stalled receiver holds the output register; the queue still takes up to
// two more samples before i_in.ready falls.
// ----------------------------------------------------------------------------
module grid3d_vector_block_average
    import gvba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    gvba_in_if.sink          i_in,
    gvba_out_if.source       o_out
);

    logic  push, q_ready, q_valid, pop;
    t_item f_item, q_item;
    t_vol  vol;

    gvba_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (i_in),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_item     (f_item),
        .o_vol      (vol)
    );

    gvba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    gvba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .i_vol     (vol),
        .m_out     (o_out)
    );

endmodule

// ===== hdl/gvba_front.sv =====
// ----------------------------------------------------------------------------
// gvba_front
// Holds the configuration, tracks the grid position and classifies samples.
// ----------------------------------------------------------------------------
module gvba_front
    import gvba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    gvba_in_if.sink          s_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output t_item            o_item,
    output t_vol             o_vol
);

    logic [DIM_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [BLK_W-1:0] r_blk;
    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z, n_pos_x, n_pos_y, n_pos_z;
    logic [POS_W-1:0] r_base_x, r_base_y, r_base_z, n_base_x, n_base_y, n_base_z;
    logic [MOD_W-1:0] r_mod_x, r_mod_y, r_mod_z, n_mod_x, n_mod_y, n_mod_z;
    logic [POS_W-1:0] r_cell_y, r_cell_z, n_cell_y, n_cell_z;

    logic [DIM_W-1:0] sx, sy, sz;
    logic [BLK_W-1:0] b;
    logic [MOD_W-1:0] bm1;
    logic             ok_x, ok_y, ok_z, lst_x, lst_y, lst_z;
    logic             wrap_x, wrap_y, wrap_z, accept;

    assign sx  = clamp_dim(r_size_x);
    assign sy  = clamp_dim(r_size_y);
    assign sz  = clamp_dim(r_size_z);
    assign b   = clamp_blk(r_blk);
    assign bm1 = MOD_W'(b - BLK_W'(1));
    assign o_vol = vol_of(b);

    // A cell exists when it fits inside the grid; it is the last on its axis
    // when the following cell would not fit.
    assign ok_x  = ({2'b0, r_base_x} + (DIM_W+1)'(b)) <= {1'b0, sx};
    assign ok_y  = ({2'b0, r_base_y} + (DIM_W+1)'(b)) <= {1'b0, sy};
    assign ok_z  = ({2'b0, r_base_z} + (DIM_W+1)'(b)) <= {1'b0, sz};
    assign lst_x = ({2'b0, r_base_x} + (DIM_W+1)'({b, 1'b0})) > {1'b0, sx};
    assign lst_y = ({2'b0, r_base_y} + (DIM_W+1)'({b, 1'b0})) > {1'b0, sy};
    assign lst_z = ({2'b0, r_base_z} + (DIM_W+1)'({b, 1'b0})) > {1'b0, sz};

    assign wrap_x = {1'b0, r_pos_x} == sx - DIM_W'(1);
    assign wrap_y = {1'b0, r_pos_y} == sy - DIM_W'(1);
    assign wrap_z = {1'b0, r_pos_z} == sz - DIM_W'(1);

    assign s_in.ready = i_q_ready;
    assign accept     = s_in.valid && i_q_ready;
    assign o_push     = accept && ok_x && ok_y && ok_z;

    always_comb begin
        o_item.vx    = s_in.in_vx;
        o_item.vy    = s_in.in_vy;
        o_item.vz    = s_in.in_vz;
        o_item.idx   = {r_cell_y, r_cell_z};
        o_item.first = (r_mod_x == '0) && (r_mod_y == '0) && (r_mod_z == '0);
        o_item.last  = (r_mod_x == bm1) && (r_mod_y == bm1) && (r_mod_z == bm1);
        o_item.fin   = o_item.last && lst_x && lst_y && lst_z;
    end

    always_comb begin
        n_pos_x = r_pos_x; n_base_x = r_base_x; n_mod_x = r_mod_x;
        n_pos_y = r_pos_y; n_base_y = r_base_y; n_mod_y = r_mod_y; n_cell_y = r_cell_y;
        n_pos_z = r_pos_z; n_base_z = r_base_z; n_mod_z = r_mod_z; n_cell_z = r_cell_z;
        if (wrap_z) begin
            n_pos_z = '0; n_base_z = '0; n_mod_z = '0; n_cell_z = '0;
            if (wrap_y) begin
                n_pos_y = '0; n_base_y = '0; n_mod_y = '0; n_cell_y = '0;
                if (wrap_x) begin
                    n_pos_x = '0; n_base_x = '0; n_mod_x = '0;
                end else begin
                    n_pos_x = r_pos_x + POS_W'(1);
                    if (r_mod_x == bm1) begin
                        n_mod_x  = '0;
                        n_base_x = r_base_x + POS_W'(b);
                    end else begin
                        n_mod_x = r_mod_x + MOD_W'(1);
                    end
                end
            end else begin
                n_pos_y = r_pos_y + POS_W'(1);
                if (r_mod_y == bm1) begin
                    n_mod_y  = '0;
                    n_base_y = r_base_y + POS_W'(b);
                    n_cell_y = r_cell_y + POS_W'(1);
                end else begin
                    n_mod_y = r_mod_y + MOD_W'(1);
                end
            end
        end else begin
            n_pos_z = r_pos_z + POS_W'(1);
            if (r_mod_z == bm1) begin
                n_mod_z  = '0;
                n_base_z = r_base_z + POS_W'(b);
                n_cell_z = r_cell_z + POS_W'(1);
            end else begin
                n_mod_z = r_mod_z + MOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= DIM_W'(MAX_DIM);
            r_size_y <= DIM_W'(MAX_DIM);
            r_size_z <= DIM_W'(MAX_DIM);
            r_blk    <= BLK_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                REG_BLOCK:  r_blk    <= i_cfg_data[BLK_W-1:0];
                default:    r_blk    <= r_blk;
            endcase
        end
    end

    // Any register write restarts the grid at the origin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_pos_x <= '0; r_base_x <= '0; r_mod_x <= '0;
            r_pos_y <= '0; r_base_y <= '0; r_mod_y <= '0; r_cell_y <= '0;
            r_pos_z <= '0; r_base_z <= '0; r_mod_z <= '0; r_cell_z <= '0;
        end else if (accept) begin
            r_pos_x <= n_pos_x; r_base_x <= n_base_x; r_mod_x <= n_mod_x;
            r_pos_y <= n_pos_y; r_base_y <= n_base_y; r_mod_y <= n_mod_y;
            r_cell_y <= n_cell_y;
            r_pos_z <= n_pos_z; r_base_z <= n_base_z; r_mod_z <= n_mod_z;
            r_cell_z <= n_cell_z;
        end
    end

endmodule

// ===== hdl/gvba_queue.sv =====
// ----------------------------------------------------------------------------
// gvba_queue
// Short first-in first-out queue of classified samples.
// ----------------------------------------------------------------------------
module gvba_queue
    import gvba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_item                r_mem [QDEPTH];
    logic [PTR_W-1:0]     r_wp, r_rp;
    logic [PTR_W:0]       r_cnt;
    logic                 do_push, do_pop;

    assign o_ready = r_cnt != (PTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + PTR_W'(1);
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== hdl/gvba_div.sv =====
// ----------------------------------------------------------------------------
// gvba_div
// Three-lane restoring divider: one quotient bit per lane each cycle.
// ----------------------------------------------------------------------------
module gvba_div
    import gvba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    input  t_vol     i_vol,
    output t_div_rsp o_rsp
);

    logic [SUM_W-1:0] r_n   [3];
    logic [VOL_W-1:0] r_rem [3];
    logic             r_neg [3];
    logic [CNT_W-1:0] r_cnt;
    t_vol             r_d;
    t_sum             sums  [3];
    logic [SUM_W-1:0] quo   [3];

    assign sums[0] = i_req.sx;
    assign sums[1] = i_req.sy;
    assign sums[2] = i_req.sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CNT_W'(SUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [VOL_W:0] t;
        if (i_req.start) begin
            r_d <= i_vol;
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= sums[k][SUM_W-1];
                r_n[k]   <= sums[k][SUM_W-1] ? SUM_W'(-sums[k]) : SUM_W'(sums[k]);
                r_rem[k] <= '0;
            end
        end else if (r_cnt != '0) begin
            for (int k = 0; k < 3; k++) begin
                t = {r_rem[k], r_n[k][SUM_W-1]};
                if (t >= {1'b0, r_d}) begin
                    r_rem[k] <= VOL_W'(t - {1'b0, r_d});
                    r_n[k]   <= {r_n[k][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= VOL_W'(t);
                    r_n[k]   <= {r_n[k][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Quotients are truncated toward zero: divide magnitudes, then restore sign.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quo[k] = r_neg[k] ? (~r_n[k] + SUM_W'(1)) : r_n[k];
        end
        o_rsp.busy = r_cnt != '0;
        o_rsp.qx   = quo[0][SAMPLE_WIDTH-1:0];
        o_rsp.qy   = quo[1][SAMPLE_WIDTH-1:0];
        o_rsp.qz   = quo[2][SAMPLE_WIDTH-1:0];
    end

endmodule

// ===== hdl/gvba_back.sv =====
// ----------------------------------------------------------------------------
// gvba_back
// Accumulates samples into the cell store and issues finished averages.
// ----------------------------------------------------------------------------
module gvba_back
    import gvba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_item    i_q_item,
    output logic     o_pop,
    input  t_vol     i_vol,
    gvba_out_if.source m_out
);

    logic [3*SUM_W-1:0] r_mem [DEPTH];
    logic [3*SUM_W-1:0] r_rd;
    t_state             r_state, n_state;
    t_item              r_item;
    logic               r_fin;
    logic               r_out_valid;
    t_sample            r_avg_x, r_avg_y, r_avg_z;
    logic               r_out_fin;
    t_sum               acc_x, acc_y, acc_z;
    logic               wr_en, load_out, out_free;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign out_free = !r_out_valid || m_out.ready;

    // The first sample of a cell ignores whatever the store held before.
    always_comb begin
        t_sum bx, by, bz;
        bx = r_item.first ? '0 : t_sum'(r_rd[3*SUM_W-1:2*SUM_W]);
        by = r_item.first ? '0 : t_sum'(r_rd[2*SUM_W-1:SUM_W]);
        bz = r_item.first ? '0 : t_sum'(r_rd[SUM_W-1:0]);
        acc_x = bx + {{(SUM_W-SAMPLE_WIDTH){r_item.vx[SAMPLE_WIDTH-1]}}, r_item.vx};
        acc_y = by + {{(SUM_W-SAMPLE_WIDTH){r_item.vy[SAMPLE_WIDTH-1]}}, r_item.vy};
        acc_z = bz + {{(SUM_W-SAMPLE_WIDTH){r_item.vz[SAMPLE_WIDTH-1]}}, r_item.vz};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_ACC;
            ST_ACC:  n_state = r_item.last ? ST_DIV : ST_IDLE;
            ST_DIV:  if (!div_rsp.busy) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = r_state == ST_IDLE && i_q_valid;
        wr_en    = r_state == ST_ACC;
        load_out = r_state == ST_OUT && out_free;
        div_req.start = r_state == ST_ACC && r_item.last;
        div_req.sx    = acc_x;
        div_req.sy    = acc_y;
        div_req.sz    = acc_z;
    end

    gvba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_vol   (i_vol),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_item.idx] <= {acc_x, acc_y, acc_z};
        r_rd <= r_mem[i_q_item.idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_q_item;
        if (div_req.start) r_fin <= r_item.fin;
        if (load_out) begin
            r_avg_x   <= div_rsp.qx;
            r_avg_y   <= div_rsp.qy;
            r_avg_z   <= div_rsp.qz;
            r_out_fin <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (m_out.ready) r_out_valid <= 1'b0;
        end
    end

    assign m_out.valid      = r_out_valid;
    assign m_out.avg_x      = r_avg_x;
    assign m_out.avg_y      = r_avg_y;
    assign m_out.avg_z      = r_avg_z;
    assign m_out.final_cell = r_out_fin;

endmodule

// ===== hdl/gvba_checker.sv =====
// ----------------------------------------------------------------------------
// gvba_checker
// Port-level checks of the block averager, bound to the top level.
// ----------------------------------------------------------------------------
module gvba_port_props
    import gvba_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input t_sample avg_x,
    input t_sample avg_y
);

    // A stalled word holds its x and y averages.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(avg_x) && $stable(avg_y))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(out_valid))
        else $error("output valid is unknown");

endmodule

bind grid3d_vector_block_average gvba_port_props u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .avg_x     (o_out.avg_x),
    .avg_y     (o_out.avg_y)
);

// ===== tb/gvba_checker.sv =====
// ----------------------------------------------------------------------------
// gvba_checker
// Watches the sample and average channels of the 3D block averager, predicts
// every average word from the accepted samples and compares field by field.
// ----------------------------------------------------------------------------
module gvba_checker
    import gvba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    gvba_in_if               in_ch,
    gvba_out_if              out_ch,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct {
        t_sample ax;
        t_sample ay;
        t_sample az;
        logic    fin;
    } t_avg_word;

    t_avg_word  avg_expected[$];
    logic [6:0] grid_x, grid_y, grid_z;
    logic [3:0] cube_edge;
    int         at_x, at_y, at_z;
    longint     acc_x[DEPTH];
    longint     acc_y[DEPTH];
    longint     acc_z[DEPTH];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int limit_dim(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_grid();
        at_x = 0;
        at_y = 0;
        at_z = 0;
        for (int k = 0; k < DEPTH; k++) begin
            acc_x[k] = 0;
            acc_y[k] = 0;
            acc_z[k] = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Accumulates one sample into its cell and queues the average when the
    // cell is complete.
    task automatic pool_sample(input t_sample vx, input t_sample vy, input t_sample vz);
        int        sx, sy, sz, b, nx, ny, nz, cx, cy, cz, idx;
        longint    vol;
        t_avg_word w;
        sx = limit_dim(grid_x, MAX_DIM);
        sy = limit_dim(grid_y, MAX_DIM);
        sz = limit_dim(grid_z, MAX_DIM);
        b  = limit_dim(cube_edge, MAX_BLOCK);
        nx = sx / b;
        ny = sy / b;
        nz = sz / b;
        cx = at_x / b;
        cy = at_y / b;
        cz = at_z / b;
        if (cx < nx && cy < ny && cz < nz) begin
            idx = (cy * MAX_DIM + cz) % DEPTH;
            acc_x[idx] += longint'(vx);
            acc_y[idx] += longint'(vy);
            acc_z[idx] += longint'(vz);
            if (at_x % b == b - 1 && at_y % b == b - 1 && at_z % b == b - 1) begin
                vol  = b * b * b;
                w.ax = t_sample'(acc_x[idx] / vol);
                w.ay = t_sample'(acc_y[idx] / vol);
                w.az = t_sample'(acc_z[idx] / vol);
                w.fin = (cx == nx - 1 && cy == ny - 1 && cz == nz - 1);
                avg_expected.push_back(w);
                acc_x[idx] = 0;
                acc_y[idx] = 0;
                acc_z[idx] = 0;
            end
        end
        at_z++;
        if (at_z >= sz) begin
            at_z = 0;
            at_y++;
            if (at_y >= sy) begin
                at_y = 0;
                at_x++;
                if (at_x >= sx) at_x = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_avg_word w;
        if (!i_rst_n) begin
            grid_x    = 7'd64;
            grid_y    = 7'd64;
            grid_z    = 7'd64;
            cube_edge = 4'd2;
            restart_grid();
            avg_expected.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (avg_expected.size() == 0) begin
                    report_mismatch("unexpected word", out_ch.avg_x, 0);
                end else begin
                    w = avg_expected.pop_front();
                    if (out_ch.avg_x !== w.ax) report_mismatch("avg_x", out_ch.avg_x, w.ax);
                    if (out_ch.avg_y !== w.ay) report_mismatch("avg_y", out_ch.avg_y, w.ay);
                    if (out_ch.avg_z !== w.az) report_mismatch("avg_z", out_ch.avg_z, w.az);
                    if (out_ch.final_cell !== w.fin) begin
                        report_mismatch("final_cell", out_ch.final_cell, w.fin);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pool_sample(in_ch.in_vx, in_ch.in_vy, in_ch.in_vz);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SIZE_X: grid_x = i_cfg_data;
                    REG_SIZE_Y: grid_y = i_cfg_data;
                    REG_SIZE_Z: grid_z = i_cfg_data;
                    REG_BLOCK:  cube_edge = i_cfg_data[3:0];
                    default: ;
                endcase
                restart_grid();
            end
        end
        o_pending = avg_expected.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3D block averager under random flow control.
// ----------------------------------------------------------------------------
// Registers are set between phases once all averages are out; each phase
// streams samples, first a directed set and then random grids and words.
// ----------------------------------------------------------------------------
module tb_top;
    import gvba_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;
    int               tx_idle;
    int               rx_idle;
    logic             rx_hold;
    int               sent;

    gvba_in_if  in_ch ();
    gvba_out_if out_ch ();

    grid3d_vector_block_average u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    gvba_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ch.ready = !rx_hold && ($urandom_range(0, 99) >= rx_idle);
    end

    function automatic t_sample rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return t_sample'($urandom_range(0, 255)) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DIM_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz, input int b);
        write_reg(REG_SIZE_X, DIM_W'(sx));
        write_reg(REG_SIZE_Y, DIM_W'(sy));
        write_reg(REG_SIZE_Z, DIM_W'(sz));
        // Upper data bits are junk for the 4-bit block register.
        write_reg(REG_BLOCK, {3'($urandom), 4'(b)});
    endtask

    task automatic push_sample(input t_sample vx, input t_sample vy, input t_sample vz);
        while ($urandom_range(0, 99) < tx_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.in_vx = vx;
        in_ch.in_vy = vy;
        in_ch.in_vz = vz;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Lets every expected word come out, then idles on for samples that are
    // still in the queue or the back and produce no word.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold = 1'b1;
        repeat (cycles) @(negedge i_clk);
        rx_hold = 1'b0;
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 64;
            2: return $urandom_range(65, 127);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int pick_block();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(9, 15);
            2: return 8;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    function automatic int clamp_for_count(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    initial begin
        int sx, sy, sz, b, n;
        in_ch.valid  = 1'b0;
        in_ch.in_vx  = '0;
        in_ch.in_vy  = '0;
        in_ch.in_vz  = '0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        rx_hold      = 1'b0;
        tx_idle      = 12;
        rx_idle      = 48;
        sent         = 0;
        i_rst_n      = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: a few samples that complete no cell.
        for (int k = 0; k < 4; k++) push_sample(rand_word(), rand_word(), rand_word());
        drain();
        // Largest positive and negative cubes.
        set_grid(2, 2, 2, 2);
        for (int k = 0; k < 8; k++) push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int k = 0; k < 8; k++) push_sample(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();
        // Single-sample cells, every one the last of its grid.
        set_grid(1, 1, 1, 1);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        push_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001);
        drain();
        // Block larger than the grid yields nothing.
        set_grid(3, 3, 3, 5);
        for (int k = 0; k < 3; k++) push_sample(rand_word(), rand_word(), rand_word());
        drain();

        // The receiver stops long enough for the input to back up.
        set_grid(4, 4, 4, 1);
        fork
            hold_receiver(400);
        join_none
        for (int k = 0; k < 64; k++) push_sample(rand_word(), rand_word(), rand_word());
        drain();

        // One full cube of the largest edge.
        set_grid(8, 8, 8, 8);
        for (int k = 0; k < 512; k++) push_sample($urandom, $urandom, $urandom);
        drain();

        while (sent < 1650) begin
            if (sent > 1100) begin
                tx_idle = 0;
                rx_idle = 0;
            end else if (sent > 800) begin
                tx_idle = 48;
                rx_idle = 12;
            end
            sx = pick_size();
            sy = pick_size();
            sz = pick_size();
            b  = pick_block();
            set_grid(sx, sy, sz, b);
            n = clamp_for_count(sx, MAX_DIM) * clamp_for_count(sy, MAX_DIM)
                * clamp_for_count(sz, MAX_DIM);
            n = n * $urandom_range(1, 2) + $urandom_range(0, 5);
            if (n > 200) n = 200;
            for (int k = 0; k < n; k++) push_sample(rand_word(), rand_word(), rand_word());
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
